/* hw/rtl/spqp_pkg.sv */
// ----------------------------------------------------------------------------
// spqp_pkg
// Shared types and constants of the strict priority class queue picker:
// request and result codes, field widths, the command passed from the
// front end to the picker.
// ----------------------------------------------------------------------------
package spqp_pkg;

  localparam int IN_TASK_W  = 16;
  localparam int IN_CLASS_W = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int REG_COUNT  = 8;

  localparam logic [CFG_W-1:0] NO_CLASS = CFG_W'(8);

  typedef enum logic [0:0] {
    REQ_ADD  = 1'b0,
    REQ_NEXT = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GIVEN   = 2'd0,
    ST_REST    = 2'd1,
    ST_ADDED   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic                  is_next;
    logic                  cls_ok;
    logic [IN_CLASS_W-1:0] cls;
    logic [IN_TASK_W-1:0]  task_id;
  } cmd_t;

endpackage

/* hw/rtl/spqp_front.sv */
// ----------------------------------------------------------------------------
// spqp_front
// Front end: accepts requests, decodes kind and class range, and holds them
// in a two-entry command queue ahead of the picker.
// ----------------------------------------------------------------------------
module spqp_front import spqp_pkg::*; #(
  parameter int CLASS_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [IN_TASK_W-1:0]  in_task_ident,
  input  logic [IN_CLASS_W-1:0] in_class_ident,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = entry_r[rd_ptr_r];

  always_comb begin
    cmd_in.is_next = (in_req_type == REQ_NEXT);
    cmd_in.cls_ok  = (int'(in_class_ident) < CLASS_COUNT);
    cmd_in.cls     = in_class_ident;
    cmd_in.task_id = in_task_ident;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* hw/rtl/spqp_picker.sv */
// ----------------------------------------------------------------------------
// spqp_picker
// Back end: per-class FIFO pointers, the task memory, the level table and
// the strict priority pick; drives the registered result channel.
// ----------------------------------------------------------------------------
module spqp_picker import spqp_pkg::*; #(
  parameter int CLASS_COUNT = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_COUNT = 8,
  parameter int TASK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IN_TASK_W-1:0]  out_task,
  output logic [IN_CLASS_W-1:0] out_class
);

  localparam int CW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int TW        = (TASK_BITS < IN_TASK_W) ? TASK_BITS : IN_TASK_W;
  localparam int MEM_DEPTH = CLASS_COUNT << PW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r  [REG_COUNT];
  logic [PW-1:0]       head_r [CLASS_COUNT];
  logic [PW-1:0]       tail_r [CLASS_COUNT];
  logic [FW-1:0]       fill_r [CLASS_COUNT];
  logic [TW-1:0]       mem    [MEM_DEPTH];
  logic [TW-1:0]       rdata_r;
  logic [CW-1:0]       rd_cls_r;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [IN_TASK_W-1:0]  out_task_r, out_task_nxt;
  logic [IN_CLASS_W-1:0] out_class_r, out_class_nxt;

  logic [CLASS_COUNT-1:0] nonempty;
  logic                hit;
  logic [CW-1:0]       pick_cls;
  logic [CW-1:0]       sel_cls;
  logic                out_free;
  logic                take;
  logic                add_ok;
  logic                do_add;
  logic                do_pop;
  logic                mem_re;
  logic [CW+PW-1:0]    waddr;
  logic [CW+PW-1:0]    raddr;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos);
    return (pos == PW'(QUEUE_DEPTH - 1)) ? '0 : pos + PW'(1);
  endfunction

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      nonempty[c] = (fill_r[c] != '0);
    end
  end

  // ascending scan: the highest eligible level wins
  always_comb begin
    hit      = 1'b0;
    pick_cls = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if ((int'(cfg_r[l]) < CLASS_COUNT) && nonempty[CW'(cfg_r[l])]) begin
        hit      = 1'b1;
        pick_cls = CW'(cfg_r[l]);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign take     = (state_r == S_IDLE) && cmd_valid && out_free;
  assign sel_cls  = cmd.is_next ? pick_cls : CW'(cmd.cls);
  assign add_ok   = cmd.cls_ok && (fill_r[sel_cls] < FW'(QUEUE_DEPTH));
  assign do_add   = take && !cmd.is_next && add_ok;
  assign do_pop   = take && cmd.is_next && hit;
  assign mem_re   = do_pop;
  assign waddr    = {sel_cls, tail_r[sel_cls]};
  assign raddr    = {sel_cls, head_r[sel_cls]};
  assign cmd_pop  = take;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_class_nxt  = out_class_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          out_task_nxt  = '0;
          out_class_nxt = '0;
          if (!cmd.is_next) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = add_ok ? ST_ADDED : ST_DROPPED;
          end else if (!hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_REST;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_GIVEN;
          out_task_nxt   = IN_TASK_W'(rdata_r);
          out_class_nxt  = IN_CLASS_W'(rd_cls_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_r[i] <= NO_CLASS;
      end
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        fill_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r[cfg_index] <= cfg_wdata;
      end
      if (do_add) begin
        tail_r[sel_cls] <= advance(tail_r[sel_cls]);
        fill_r[sel_cls] <= fill_r[sel_cls] + FW'(1);
      end
      if (do_pop) begin
        head_r[sel_cls] <= advance(head_r[sel_cls]);
        fill_r[sel_cls] <= fill_r[sel_cls] - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_class_r  <= out_class_nxt;
    if (mem_re) begin
      rd_cls_r <= pick_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[waddr] <= cmd.task_id[TW-1:0];
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_task   = out_task_r;
  assign out_class  = out_class_r;

endmodule

/* hw/rtl/strict_priority_class_queue_picker_core.sv */
// Order: a request waits in the command queue until the picker takes it; an
// add result is then registered, while a next request first passes the
// registered task memory read (S_READ). Throughput: one add per cycle while
// the result is not stalled; no new request is taken while in S_READ.
// Reset (synchronous, rst_n low): queues empty, all levels set to no class;
// the task memory is not cleared.
// ----------------------------------------------------------------------------
// strict_priority_class_queue_picker_core
// Per-class task FIFOs with a configurable strict priority level table:
// front end decode and command queue, back end pick and pop.
// ----------------------------------------------------------------------------
module strict_priority_class_queue_picker_core import spqp_pkg::*; #(
  parameter int CLASS_COUNT = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_COUNT = 8,
  parameter int TASK_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [IN_TASK_W-1:0]  in_task_ident,
  input  logic [IN_CLASS_W-1:0] in_class_ident,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IN_TASK_W-1:0]  out_task,
  output logic [IN_CLASS_W-1:0] out_class,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  spqp_front #(
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_task_ident  (in_task_ident),
    .in_class_ident (in_class_ident),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  spqp_picker #(
    .CLASS_COUNT(CLASS_COUNT),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LEVEL_COUNT(LEVEL_COUNT),
    .TASK_BITS  (TASK_BITS)
  ) u_picker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_task   (out_task),
    .out_class  (out_class)
  );

endmodule

/* hw/rtl/spqp_checker.sv */
// ----------------------------------------------------------------------------
// spqp_checker
// Port-level checks of the picker core, bound to the top level.
// ----------------------------------------------------------------------------
module spqp_checker import spqp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   out_status,
  input logic [IN_TASK_W-1:0]  out_task,
  input logic [IN_CLASS_W-1:0] out_class
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_task) && $stable(out_class))
    else $error("result changed while stalled");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GIVEN) |-> (out_task == '0) && (out_class == '0))
    else $error("task or class nonzero on a non-given result");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("request channel stalled after reset");

endmodule

bind strict_priority_class_queue_picker_core spqp_checker u_spqp_checker (.*);
